FILE: hdl/hsv_pkg.sv
package hsv_pkg;

   localparam int CHANNEL_FRAC_BITS = 8;

   localparam int HUE_WIDTH      = 15;
   localparam int HUE_FRAC_BITS  = 6;
   localparam int DEG_PER_SECTOR = 60;
   localparam int SECTOR_UNITS   = DEG_PER_SECTOR << HUE_FRAC_BITS;
   localparam int SECTOR_COUNT   = 6;
   localparam int HUE_MAX        = SECTOR_UNITS * SECTOR_COUNT;
   localparam int WEIGHT_WIDTH   = 12;

   // One sector span is 15 << 8, so a division by it is a shift and a divide by 15.
   localparam int SECTOR_SHIFT   = 8;
   localparam int SECTOR_DIVISOR = SECTOR_UNITS >> SECTOR_SHIFT;

   typedef logic [2:0] sector_type;

   localparam sector_type SEC_RED_YELLOW    = 3'd0;
   localparam sector_type SEC_YELLOW_GREEN  = 3'd1;
   localparam sector_type SEC_GREEN_CYAN    = 3'd2;
   localparam sector_type SEC_CYAN_BLUE     = 3'd3;
   localparam sector_type SEC_BLUE_MAGENTA  = 3'd4;
   localparam sector_type SEC_MAGENTA_RED   = 3'd5;

   typedef struct packed {
      logic       valid;
      sector_type sector;
   } hsv_ctl_type;

endpackage

FILE: hdl/hsv_to_rgb_converter_unit.sv
// HSV to RGB pixel converter.
// Input: drive req_hue_deg (1/64 degree, 0 to 360 degrees), req_sat_level and
// req_val_level (Q1.FRAC_BITS, one is 1.0) and raise start for one cycle per
// pixel. A beat is taken at every clock edge where start is high and busy is
// low; busy is never raised, so one pixel can enter on every clock.
// Output: rsp_strobe is high for exactly one cycle per pixel, with
// rsp_red_out, rsp_green_out and rsp_blue_out valid in that same cycle. The
// result passes through every register stage listed below, and results come
// out in input order. Throughput is one pixel per clock.
// The pipeline has five register stages: sector split and clamps, chroma
// multiply, chroma-times-weight multiply, reciprocal multiply for the divide
// by 15, and a correction, channel routing and saturation stage.
// The receiver has no way to stall the pipeline, so it must take each result
// in the cycle that rsp_strobe marks it.
// Reset clears every valid bit; beats in flight at reset are dropped and no
// strobe appears until new beats have gone through.
module hsv_to_rgb_converter_unit #(
   parameter int FRAC_BITS = hsv_pkg::CHANNEL_FRAC_BITS
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic [hsv_pkg::HUE_WIDTH-1:0]    req_hue_deg,
   input  logic [FRAC_BITS:0]               req_sat_level,
   input  logic [FRAC_BITS:0]               req_val_level,
   output logic                             rsp_strobe,
   output logic [FRAC_BITS:0]               rsp_red_out,
   output logic [FRAC_BITS:0]               rsp_green_out,
   output logic [FRAC_BITS:0]               rsp_blue_out
);

   localparam int LW      = FRAC_BITS + 1;
   localparam int QW      = LW + hsv_pkg::WEIGHT_WIDTH - hsv_pkg::SECTOR_SHIFT;
   localparam int LATENCY = 5;
   localparam logic [LW-1:0] LEVEL_ONE = {1'b1, {FRAC_BITS{1'b0}}};

   hsv_pkg::hsv_ctl_type                 sec_ctl;
   logic [hsv_pkg::WEIGHT_WIDTH-1:0]     sec_weight;
   logic [LW-1:0]                        sec_sat;
   logic [LW-1:0]                        sec_val;

   hsv_pkg::hsv_ctl_type                 prod_ctl;
   logic [QW-1:0]                        prod_quot;
   logic [LW-1:0]                        prod_chroma;
   logic [LW-1:0]                        prod_base;

   hsv_pkg::hsv_ctl_type                 scale_ctl;
   logic [QW-1:0]                        scale_quot;
   logic [QW-1:0]                        scale_est;
   logic [LW-1:0]                        scale_chroma;
   logic [LW-1:0]                        scale_base;

   assign busy = 1'b0;

   hsv_sector_stage #(
      .FRAC_BITS(FRAC_BITS)
   ) u_sector (
      .clock      (clock),
      .reset      (reset),
      .beat_valid (start & ~busy),
      .hue        (req_hue_deg),
      .sat        (req_sat_level),
      .val        (req_val_level),
      .ctl_ff     (sec_ctl),
      .weight_ff  (sec_weight),
      .sat_ff     (sec_sat),
      .val_ff     (sec_val)
   );

   hsv_product_stage #(
      .FRAC_BITS(FRAC_BITS)
   ) u_product (
      .clock     (clock),
      .reset     (reset),
      .ctl       (sec_ctl),
      .weight    (sec_weight),
      .sat       (sec_sat),
      .val       (sec_val),
      .ctl_ff    (prod_ctl),
      .quot_ff   (prod_quot),
      .chroma_ff (prod_chroma),
      .base_ff   (prod_base)
   );

   hsv_scale_stage #(
      .FRAC_BITS(FRAC_BITS)
   ) u_scale (
      .clock     (clock),
      .reset     (reset),
      .ctl       (prod_ctl),
      .quot      (prod_quot),
      .chroma    (prod_chroma),
      .base      (prod_base),
      .ctl_ff    (scale_ctl),
      .quot_ff   (scale_quot),
      .est_ff    (scale_est),
      .chroma_ff (scale_chroma),
      .base_ff   (scale_base)
   );

   hsv_mix_stage #(
      .FRAC_BITS(FRAC_BITS)
   ) u_mix (
      .clock     (clock),
      .reset     (reset),
      .ctl       (scale_ctl),
      .quot      (scale_quot),
      .est       (scale_est),
      .chroma    (scale_chroma),
      .base      (scale_base),
      .strobe_ff (rsp_strobe),
      .red_ff    (rsp_red_out),
      .green_ff  (rsp_green_out),
      .blue_ff   (rsp_blue_out)
   );

`ifndef ASSERT_OFF
   // Every beat taken comes out as exactly one result after the fixed latency.
   a_beat_to_result: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##LATENCY rsp_strobe)
      else $error("accepted beat produced no result");

   a_result_has_beat: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start && !busy, LATENCY))
      else $error("result without an accepted beat");

   a_channels_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_red_out <= LEVEL_ONE && rsp_green_out <= LEVEL_ONE
                      && rsp_blue_out <= LEVEL_ONE))
      else $error("channel above full scale");

   // The strongest channel always carries chroma plus the base, which is the value.
   a_peak_is_value: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |->
         (rsp_red_out == (($past(req_val_level, LATENCY) > LEVEL_ONE) ? LEVEL_ONE
                          : $past(req_val_level, LATENCY))
          || rsp_green_out == (($past(req_val_level, LATENCY) > LEVEL_ONE) ? LEVEL_ONE
                               : $past(req_val_level, LATENCY))
          || rsp_blue_out == (($past(req_val_level, LATENCY) > LEVEL_ONE) ? LEVEL_ONE
                              : $past(req_val_level, LATENCY))))
      else $error("no channel equals the pixel value");
`endif

endmodule

FILE: hdl/hsv_sector_stage.sv
module hsv_sector_stage #(
   parameter int FRAC_BITS = hsv_pkg::CHANNEL_FRAC_BITS
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  beat_valid,
   input  logic [hsv_pkg::HUE_WIDTH-1:0]         hue,
   input  logic [FRAC_BITS:0]                    sat,
   input  logic [FRAC_BITS:0]                    val,
   output hsv_pkg::hsv_ctl_type                  ctl_ff,
   output logic [hsv_pkg::WEIGHT_WIDTH-1:0]      weight_ff,
   output logic [FRAC_BITS:0]                    sat_ff,
   output logic [FRAC_BITS:0]                    val_ff
);

   localparam int HW = hsv_pkg::HUE_WIDTH;
   localparam int WW = hsv_pkg::WEIGHT_WIDTH;
   localparam int SU = hsv_pkg::SECTOR_UNITS;
   localparam logic [FRAC_BITS:0] LEVEL_ONE = {1'b1, {FRAC_BITS{1'b0}}};

   hsv_pkg::hsv_ctl_type     ctl_in;
   logic [WW-1:0]            weight_in;
   logic [FRAC_BITS:0]       sat_in;
   logic [FRAC_BITS:0]       val_in;
   logic [HW-1:0]            hue_clamped;
   logic [HW-1:0]            sector_start;
   logic [WW-1:0]            pos;

   always_comb begin
      hue_clamped = (hue > HW'(hsv_pkg::HUE_MAX)) ? HW'(hsv_pkg::HUE_MAX) : hue;
      // The higher sector wins on an edge; a full 360 degrees lands at the far
      // edge of the last sector.
      if (hue_clamped >= HW'(5 * SU)) begin
         ctl_in.sector = hsv_pkg::SEC_MAGENTA_RED;
         sector_start  = HW'(5 * SU);
      end else if (hue_clamped >= HW'(4 * SU)) begin
         ctl_in.sector = hsv_pkg::SEC_BLUE_MAGENTA;
         sector_start  = HW'(4 * SU);
      end else if (hue_clamped >= HW'(3 * SU)) begin
         ctl_in.sector = hsv_pkg::SEC_CYAN_BLUE;
         sector_start  = HW'(3 * SU);
      end else if (hue_clamped >= HW'(2 * SU)) begin
         ctl_in.sector = hsv_pkg::SEC_GREEN_CYAN;
         sector_start  = HW'(2 * SU);
      end else if (hue_clamped >= HW'(SU)) begin
         ctl_in.sector = hsv_pkg::SEC_YELLOW_GREEN;
         sector_start  = HW'(SU);
      end else begin
         ctl_in.sector = hsv_pkg::SEC_RED_YELLOW;
         sector_start  = '0;
      end
      ctl_in.valid = beat_valid;
      pos          = WW'(hue_clamped - sector_start);
      weight_in    = ctl_in.sector[0] ? (WW'(SU) - pos) : pos;
      sat_in       = (sat > LEVEL_ONE) ? LEVEL_ONE : sat;
      val_in       = (val > LEVEL_ONE) ? LEVEL_ONE : val;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff.valid <= 1'b0;
      end else begin
         ctl_ff.valid <= ctl_in.valid;
      end
      ctl_ff.sector <= ctl_in.sector;
      weight_ff     <= weight_in;
      sat_ff        <= sat_in;
      val_ff        <= val_in;
   end

endmodule

FILE: hdl/hsv_product_stage.sv
module hsv_product_stage #(
   parameter int FRAC_BITS = hsv_pkg::CHANNEL_FRAC_BITS
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  hsv_pkg::hsv_ctl_type                    ctl,
   input  logic [hsv_pkg::WEIGHT_WIDTH-1:0]        weight,
   input  logic [FRAC_BITS:0]                      sat,
   input  logic [FRAC_BITS:0]                      val,
   output hsv_pkg::hsv_ctl_type                    ctl_ff,
   output logic [FRAC_BITS+hsv_pkg::WEIGHT_WIDTH-hsv_pkg::SECTOR_SHIFT:0] quot_ff,
   output logic [FRAC_BITS:0]                      chroma_ff,
   output logic [FRAC_BITS:0]                      base_ff
);

   localparam int LW = FRAC_BITS + 1;
   localparam int WW = hsv_pkg::WEIGHT_WIDTH;
   localparam int PW = LW + WW;
   localparam int QW = PW - hsv_pkg::SECTOR_SHIFT;

   // First register stage: chroma.
   hsv_pkg::hsv_ctl_type  mid_ctl_ff;
   logic [LW-1:0]         mid_chroma_ff;
   logic [LW-1:0]         mid_chroma_in;
   logic [LW-1:0]         mid_val_ff;
   logic [WW-1:0]         mid_weight_ff;
   logic [2*LW-1:0]       chroma_product;

   // Second register stage: chroma times weight, low byte dropped.
   logic [PW-1:0]         second_product;
   logic [QW-1:0]         quot_in;
   logic [LW-1:0]         base_in;

   always_comb begin
      chroma_product = val * sat;
      mid_chroma_in  = chroma_product[FRAC_BITS +: LW];
      second_product = mid_chroma_ff * mid_weight_ff;
      quot_in        = second_product[PW-1:hsv_pkg::SECTOR_SHIFT];
      base_in        = mid_val_ff - mid_chroma_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mid_ctl_ff.valid <= 1'b0;
         ctl_ff.valid     <= 1'b0;
      end else begin
         mid_ctl_ff.valid <= ctl.valid;
         ctl_ff.valid     <= mid_ctl_ff.valid;
      end
      mid_ctl_ff.sector <= ctl.sector;
      mid_chroma_ff     <= mid_chroma_in;
      mid_val_ff        <= val;
      mid_weight_ff     <= weight;
      ctl_ff.sector     <= mid_ctl_ff.sector;
      quot_ff           <= quot_in;
      chroma_ff         <= mid_chroma_ff;
      base_ff           <= base_in;
   end

endmodule

FILE: hdl/hsv_scale_stage.sv
module hsv_scale_stage #(
   parameter int FRAC_BITS = hsv_pkg::CHANNEL_FRAC_BITS
) (
   input  logic                   clock,
   input  logic                   reset,
   input  hsv_pkg::hsv_ctl_type   ctl,
   input  logic [FRAC_BITS+hsv_pkg::WEIGHT_WIDTH-hsv_pkg::SECTOR_SHIFT:0] quot,
   input  logic [FRAC_BITS:0]     chroma,
   input  logic [FRAC_BITS:0]     base,
   output hsv_pkg::hsv_ctl_type   ctl_ff,
   output logic [FRAC_BITS+hsv_pkg::WEIGHT_WIDTH-hsv_pkg::SECTOR_SHIFT:0] quot_ff,
   output logic [FRAC_BITS+hsv_pkg::WEIGHT_WIDTH-hsv_pkg::SECTOR_SHIFT:0] est_ff,
   output logic [FRAC_BITS:0]     chroma_ff,
   output logic [FRAC_BITS:0]     base_ff
);

   localparam int QW = FRAC_BITS + 1 + hsv_pkg::WEIGHT_WIDTH - hsv_pkg::SECTOR_SHIFT;
   // With a reciprocal of QW fraction bits the estimate is exact or one low.
   localparam longint RECIP_VALUE = (longint'(1) << QW) / hsv_pkg::SECTOR_DIVISOR;
   localparam logic [QW-1:0] RECIP = QW'(RECIP_VALUE);

   logic [2*QW-1:0] recip_product;
   logic [QW-1:0]   est_in;

   always_comb begin
      recip_product = quot * RECIP;
      est_in        = recip_product[2*QW-1:QW];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff.valid <= 1'b0;
      end else begin
         ctl_ff.valid <= ctl.valid;
      end
      ctl_ff.sector <= ctl.sector;
      quot_ff       <= quot;
      est_ff        <= est_in;
      chroma_ff     <= chroma;
      base_ff       <= base;
   end

endmodule

FILE: hdl/hsv_mix_stage.sv
module hsv_mix_stage #(
   parameter int FRAC_BITS = hsv_pkg::CHANNEL_FRAC_BITS
) (
   input  logic                   clock,
   input  logic                   reset,
   input  hsv_pkg::hsv_ctl_type   ctl,
   input  logic [FRAC_BITS+hsv_pkg::WEIGHT_WIDTH-hsv_pkg::SECTOR_SHIFT:0] quot,
   input  logic [FRAC_BITS+hsv_pkg::WEIGHT_WIDTH-hsv_pkg::SECTOR_SHIFT:0] est,
   input  logic [FRAC_BITS:0]     chroma,
   input  logic [FRAC_BITS:0]     base,
   output logic                   strobe_ff,
   output logic [FRAC_BITS:0]     red_ff,
   output logic [FRAC_BITS:0]     green_ff,
   output logic [FRAC_BITS:0]     blue_ff
);

   localparam int LW = FRAC_BITS + 1;
   localparam int QW = LW + hsv_pkg::WEIGHT_WIDTH - hsv_pkg::SECTOR_SHIFT;
   localparam logic [LW-1:0] LEVEL_ONE = {1'b1, {FRAC_BITS{1'b0}}};

   logic [QW-1:0] remainder;
   logic [QW-1:0] second_full;
   logic [LW-1:0] second;
   logic [LW-1:0] red_term;
   logic [LW-1:0] green_term;
   logic [LW-1:0] blue_term;
   logic [LW:0]   red_sum;
   logic [LW:0]   green_sum;
   logic [LW:0]   blue_sum;
   logic [LW-1:0] red_in;
   logic [LW-1:0] green_in;
   logic [LW-1:0] blue_in;

   always_comb begin
      remainder   = quot - QW'(est * hsv_pkg::SECTOR_DIVISOR);
      second_full = (remainder >= QW'(hsv_pkg::SECTOR_DIVISOR)) ? (est + 1'b1) : est;
      second      = second_full[LW-1:0];

      red_term   = '0;
      green_term = '0;
      blue_term  = '0;
      unique case (ctl.sector)
         hsv_pkg::SEC_RED_YELLOW: begin
            red_term   = chroma;
            green_term = second;
         end
         hsv_pkg::SEC_YELLOW_GREEN: begin
            red_term   = second;
            green_term = chroma;
         end
         hsv_pkg::SEC_GREEN_CYAN: begin
            green_term = chroma;
            blue_term  = second;
         end
         hsv_pkg::SEC_CYAN_BLUE: begin
            green_term = second;
            blue_term  = chroma;
         end
         hsv_pkg::SEC_BLUE_MAGENTA: begin
            red_term  = second;
            blue_term = chroma;
         end
         default: begin
            red_term  = chroma;
            blue_term = second;
         end
      endcase

      red_sum   = {1'b0, red_term} + {1'b0, base};
      green_sum = {1'b0, green_term} + {1'b0, base};
      blue_sum  = {1'b0, blue_term} + {1'b0, base};
      red_in    = (red_sum > {1'b0, LEVEL_ONE}) ? LEVEL_ONE : red_sum[LW-1:0];
      green_in  = (green_sum > {1'b0, LEVEL_ONE}) ? LEVEL_ONE : green_sum[LW-1:0];
      blue_in   = (blue_sum > {1'b0, LEVEL_ONE}) ? LEVEL_ONE : blue_sum[LW-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= ctl.valid;
      end
      red_ff   <= red_in;
      green_ff <= green_in;
      blue_ff  <= blue_in;
   end

endmodule
